// ----- rtl/tlsd_pkg.sv -----
// shared types and constants for the tls record deframer
package tlsd_pkg;

	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORD_LEN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PASSTHROUGH_COUNT = 1'd1;

	localparam logic [15:0] MAX_RECORD_LEN_RST = 16'd16384;

	localparam logic [7:0] HDR_TYPE_BYTE = 8'h17;
	localparam logic [7:0] HDR_VER_BYTE = 8'h03;

	localparam logic [2:0] HPOS_TYPE = 3'd0;
	localparam logic [2:0] HPOS_LEN_HI = 3'd3;
	localparam logic [2:0] HPOS_LEN_LO = 3'd4;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_BAD_HEADER = 2'd2;
	localparam logic [1:0] KIND_TOO_LONG = 2'd3;

	localparam logic [1:0] ERR_NONE = 2'd0;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_req;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic       record_end;
	} out_item_t;

endpackage

// ----- rtl/tlsd_framer.sv -----
// framing state, configuration registers and per-byte result logic
module tlsd_framer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tlsd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tlsd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                              accept,
	input  tlsd_pkg::in_item_t                item,
	output tlsd_pkg::out_item_t               result
);

	logic [15:0] max_record_len_q;
	logic [15:0] passthrough_count_q;

	logic [2:0]  hpos_q;
	logic [7:0]  len_hi_q;
	logic [15:0] remaining_q;
	logic [15:0] lead_left_q;
	logic [1:0]  err_q;

	// state as seen by this byte, after an optional start
	logic [2:0]  hpos_e;
	logic [7:0]  len_hi_e;
	logic [15:0] remaining_e;
	logic [15:0] lead_left_e;
	logic [1:0]  err_e;

	logic [2:0]  hpos_d;
	logic [7:0]  len_hi_d;
	logic [15:0] remaining_d;
	logic [15:0] lead_left_d;
	logic [1:0]  err_d;
	logic [7:0]  want_byte;
	logic [15:0] remaining_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_record_len_q <= tlsd_pkg::MAX_RECORD_LEN_RST;
			passthrough_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tlsd_pkg::CFG_MAX_RECORD_LEN: max_record_len_q <= cfg_wdata;
				tlsd_pkg::CFG_PASSTHROUGH_COUNT: passthrough_count_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		hpos_e = item.start_req ? tlsd_pkg::HPOS_TYPE : hpos_q;
		len_hi_e = item.start_req ? 8'd0 : len_hi_q;
		remaining_e = item.start_req ? 16'd0 : remaining_q;
		lead_left_e = item.start_req ? passthrough_count_q : lead_left_q;
		err_e = item.start_req ? tlsd_pkg::ERR_NONE : err_q;

		hpos_d = hpos_e;
		len_hi_d = len_hi_e;
		remaining_d = remaining_e;
		lead_left_d = lead_left_e;
		err_d = err_e;
		remaining_dec = remaining_e - 16'd1;
		want_byte = (hpos_e == tlsd_pkg::HPOS_TYPE) ? tlsd_pkg::HDR_TYPE_BYTE
			: tlsd_pkg::HDR_VER_BYTE;

		result.out_byte = 8'd0;
		result.kind = tlsd_pkg::KIND_HEADER;
		result.record_end = 1'b0;

		if (err_e != tlsd_pkg::ERR_NONE) begin
			result.kind = err_e;
		end else if (lead_left_e != 16'd0) begin
			lead_left_d = lead_left_e - 16'd1;
			result.out_byte = item.data_byte;
			result.kind = tlsd_pkg::KIND_PAYLOAD;
		end else if (remaining_e == 16'd0) begin
			if (hpos_e < tlsd_pkg::HPOS_LEN_HI) begin
				if (item.data_byte != want_byte) begin
					err_d = tlsd_pkg::KIND_BAD_HEADER;
					result.kind = tlsd_pkg::KIND_BAD_HEADER;
				end else begin
					hpos_d = hpos_e + 3'd1;
				end
			end else if (hpos_e == tlsd_pkg::HPOS_LEN_HI) begin
				len_hi_d = item.data_byte;
				hpos_d = tlsd_pkg::HPOS_LEN_LO;
			end else begin
				// low length byte, also covers positions above four
				remaining_d = {len_hi_e, item.data_byte};
				hpos_d = tlsd_pkg::HPOS_TYPE;
			end
		end else if (remaining_e > max_record_len_q) begin
			err_d = tlsd_pkg::KIND_TOO_LONG;
			result.kind = tlsd_pkg::KIND_TOO_LONG;
		end else begin
			remaining_d = remaining_dec;
			result.out_byte = item.data_byte;
			result.kind = tlsd_pkg::KIND_PAYLOAD;
			result.record_end = (remaining_dec == 16'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hpos_q <= tlsd_pkg::HPOS_TYPE;
			len_hi_q <= '0;
			remaining_q <= '0;
			lead_left_q <= '0;
			err_q <= tlsd_pkg::ERR_NONE;
		end else if (accept) begin
			hpos_q <= hpos_d;
			len_hi_q <= len_hi_d;
			remaining_q <= remaining_d;
			lead_left_q <= lead_left_d;
			err_q <= err_d;
		end
	end

endmodule

// ----- rtl/tls_record_deframer.sv -----
// top level of the tls application-data record deframer
// The deframer takes one raw stream byte per item and returns one result item
// for every byte: header bytes come out as kind header, payload bytes pass
// through as kind payload with record_end on the last byte of each record,
// and a malformed header or a record longer than max_record_len latches a
// sticky error (kind bad header or too long) that every later byte reports
// until the next start_req. A start_req on an item clears the framing state
// and loads passthrough_count leading bytes that pass unframed before header
// parsing begins. Throughput is one byte per clock while in_stall is low: the
// framing counters and header compare are combinational and update on
// acceptance, and the result is registered into the output register or, while
// the output is held, into a one-entry skid register. That skid register keeps
// in_stall a registered signal while out_stall is high. Configuration writes
// take effect on the next edge and are meant for idle periods.
module tls_record_deframer (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [tlsd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tlsd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	// byte input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  tlsd_pkg::in_item_t                in_data,
	// result output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output tlsd_pkg::out_item_t               out_data
);

	logic                accept;
	logic                out_fire;
	tlsd_pkg::out_item_t result;

	logic                out_valid_q;
	tlsd_pkg::out_item_t out_data_q;
	logic                skid_valid_q;
	tlsd_pkg::out_item_t skid_data_q;

	// input is held off only while the skid entry is occupied
	assign in_stall = skid_valid_q;
	assign accept = in_valid && !skid_valid_q;
	assign out_fire = out_valid_q && !out_stall;

	tlsd_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.item      (in_data),
		.result    (result)
	);

	// output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (!out_valid_q || out_fire) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_fire) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!out_valid_q || out_fire) begin
				out_data_q <= result;
			end else begin
				skid_data_q <= result;
			end
		end else if (out_fire && skid_valid_q) begin
			out_data_q <= skid_data_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule
